/* sv/bml_pkg.sv */
package bml_pkg;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_BLUE  = 3'd1,
		ACT_RED   = 3'd2,
		ACT_STEP  = 3'd3,
		ACT_READ  = 3'd4,
		ACT_CLEAR = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_P1_RD,
		ST_P1_GR,
		ST_P1_DEC,
		ST_P2_RD,
		ST_P2_WT,
		ST_P2_WP
	} state_t;

	localparam logic [1:0] CELL_EMPTY = 2'd0;
	localparam logic [1:0] CELL_RED   = 2'd1;
	localparam logic [1:0] CELL_BLUE  = 2'd2;
	localparam logic [1:0] CELL_BAD   = 2'd3;

	localparam int CFG_W = 7;
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef struct packed {
		logic       fin;
		logic [1:0] rv;
		logic       status;
		logic       phase;
	} result_t;

endpackage

/* sv/bml_ram.sv */
module bml_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/bml_traffic_step_top.sv */
// Biham-Middleton-Levine traffic automaton on a torus of up to MAX_ROWS x MAX_COLS cells.
// The grid lives in one RAM and both car lists share a second RAM. Write, add and
// out-of-range items are answered straight from the idle state, a read via a read state. An
// advance walks the cars of the moving color twice: a decision pass reads each position and
// its target cell and marks whether the car may move, then an update pass writes the moves:
// target cell set, old cell cleared, new position stored. After reset and after a clear-all
// item every cell of the grid RAM is swept, one cell a cycle, with input held off;
// configuration writes are taken at any time.
module bml_traffic_step_top import bml_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_CARS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       action,
	input  logic [5:0]       row,
	input  logic [5:0]       col,
	input  logic [1:0]       cell_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       read_value,
	output logic [10:0]      moved_count,
	output logic             phase,
	output logic             status
);

	localparam int RB  = $clog2(MAX_ROWS);
	localparam int CB  = $clog2(MAX_COLS);
	localparam int PW  = RB + CB;
	localparam int AW  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
	localparam int CW  = $clog2(MAX_CARS + 1);
	localparam int PDEPTH = 2 ** (AW + 1);
	localparam int GDEPTH = 2 ** PW;

	state_t state_q, state_d;

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [CW-1:0]    blue_cnt_q, red_cnt_q, n_q, car_q, moved_q;
	logic             phase_q, color_q, flag_q, clr_item_q;
	logic [PW-1:0]    clr_q, pos_q, tgt_q;

	logic          grid_we, pos_we;
	logic [PW-1:0] grid_waddr, grid_raddr;
	logic [1:0]    grid_wdata, grid_rdata;
	logic [AW:0]   pos_waddr, pos_raddr;
	logic [PW:0]   pos_wdata, pos_rdata;

	bml_ram #(.WIDTH(2), .DEPTH(GDEPTH)) u_grid (
		.clk(clk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
		.raddr(grid_raddr), .rdata(grid_rdata)
	);

	bml_ram #(.WIDTH(PW + 1), .DEPTH(PDEPTH)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	logic [10:0] rows11, cols11, row11, col11;
	logic [RB:0] nr;
	logic [CB:0] nc;
	logic        coord_ok, accept, car_done, clr_last, list_full;
	logic [RB-1:0] r_in, pr, tr;
	logic [CB-1:0] c_in, pc, tc;
	logic [PW-1:0] tgt;
	logic [1:0]    car_color;
	logic [CW-1:0] cnt_sel;
	action_t       act;
	result_t       res;

	assign rows11 = 11'(rows_q);
	assign cols11 = 11'(cols_q);
	assign row11  = 11'(row);
	assign col11  = 11'(col);
	assign nr = (rows11 == 11'd0) ? (RB+1)'(1) :
		(rows11 > 11'(MAX_ROWS)) ? (RB+1)'(MAX_ROWS) : (RB+1)'(rows11);
	assign nc = (cols11 == 11'd0) ? (CB+1)'(1) :
		(cols11 > 11'(MAX_COLS)) ? (CB+1)'(MAX_COLS) : (CB+1)'(cols11);
	assign coord_ok = (row11 < 11'(nr)) && (col11 < 11'(nc));
	assign r_in = RB'(row);
	assign c_in = CB'(col);
	assign act = action_t'(action);
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign car_done = (car_q == n_q);
	assign clr_last = (clr_q == {PW{1'b1}});
	assign cnt_sel = (act == ACT_RED) ? red_cnt_q : blue_cnt_q;
	assign list_full = (cnt_sel >= CW'(MAX_CARS));
	assign car_color = color_q ? CELL_RED : CELL_BLUE;

	assign pr = pos_rdata[PW-1:CB];
	assign pc = pos_rdata[CB-1:0];
	always_comb begin
		tr = pr;
		tc = pc;
		if (!color_q) begin
			tr = (pr == '0) ? RB'(nr - (RB+1)'(1)) : pr - RB'(1);
		end else begin
			tc = (((CB+1)'(pc) + (CB+1)'(1)) >= nc) ? '0 : pc + CB'(1);
		end
		tgt = {tr, tc};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (act)
						ACT_STEP:  state_d = ST_P1_RD;
						ACT_READ:  state_d = coord_ok ? ST_READ : ST_IDLE;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_P1_RD:  state_d = car_done ? ST_P2_RD : ST_P1_GR;
			ST_P1_GR:  state_d = ST_P1_DEC;
			ST_P1_DEC: state_d = ST_P1_RD;
			ST_P2_RD:  state_d = car_done ? ST_IDLE : ST_P2_WT;
			ST_P2_WT:  state_d = ST_P2_WP;
			ST_P2_WP:  state_d = ST_P2_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		grid_we    = 1'b0;
		grid_waddr = {r_in, c_in};
		grid_wdata = cell_value;
		grid_raddr = {r_in, c_in};
		pos_we     = 1'b0;
		pos_waddr  = {color_q, car_q[AW-1:0]};
		pos_wdata  = {1'b0, r_in, c_in};
		pos_raddr  = {color_q, car_q[AW-1:0]};
		res        = '{fin: 1'b0, rv: CELL_EMPTY, status: 1'b0, phase: phase_q};
		unique case (state_q)
			ST_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = clr_q;
				grid_wdata = CELL_EMPTY;
				res.fin    = clr_last && clr_item_q;
				res.phase  = 1'b0;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (act)
						ACT_WRITE: begin
							res.fin    = 1'b1;
							res.status = !coord_ok || (cell_value == CELL_BAD);
							grid_we    = !res.status;
						end
						ACT_BLUE, ACT_RED: begin
							res.fin    = 1'b1;
							res.status = !coord_ok || list_full;
							grid_we    = !res.status;
							grid_wdata = (act == ACT_RED) ? CELL_RED : CELL_BLUE;
							pos_we     = !res.status;
							pos_waddr  = {act == ACT_RED, cnt_sel[AW-1:0]};
						end
						ACT_STEP: res.fin = 1'b0;
						ACT_READ: begin
							res.fin    = !coord_ok;
							res.status = !coord_ok;
						end
						ACT_CLEAR: res.fin = 1'b0;
						default: begin
							res.fin    = 1'b1;
							res.status = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				res.fin = 1'b1;
				res.rv  = grid_rdata;
			end
			ST_P1_RD: res.fin = 1'b0;
			ST_P1_GR: grid_raddr = tgt;
			ST_P1_DEC: begin
				pos_we    = 1'b1;
				pos_wdata = {grid_rdata == CELL_EMPTY, pos_q};
			end
			ST_P2_RD: begin
				res.fin   = car_done;
				res.phase = !phase_q;
			end
			ST_P2_WT: begin
				grid_we    = pos_rdata[PW];
				grid_waddr = tgt;
				grid_wdata = car_color;
			end
			ST_P2_WP: begin
				grid_we    = flag_q;
				grid_waddr = pos_q;
				grid_wdata = CELL_EMPTY;
				pos_we     = flag_q;
				pos_wdata  = {1'b0, tgt_q};
			end
			default: res.fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			rows_q     <= CFG_W'(64);
			cols_q     <= CFG_W'(64);
			blue_cnt_q <= '0;
			red_cnt_q  <= '0;
			phase_q    <= 1'b0;
			clr_q      <= '0;
			clr_item_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == CFG_ROWS) rows_q <= cfg_wdata;
				if (cfg_index == CFG_COLS) cols_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PW'(1);
			end
			if (accept) begin
				unique case (act)
					ACT_BLUE: if (coord_ok && !list_full) blue_cnt_q <= blue_cnt_q + CW'(1);
					ACT_RED:  if (coord_ok && !list_full) red_cnt_q <= red_cnt_q + CW'(1);
					ACT_CLEAR: begin
						blue_cnt_q <= '0;
						red_cnt_q  <= '0;
						phase_q    <= 1'b0;
						clr_q      <= '0;
						clr_item_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (state_q == ST_P2_RD && car_done) begin
				phase_q <= !phase_q;
			end
			if (res.fin) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && act == ACT_STEP) begin
			color_q <= phase_q;
			n_q     <= phase_q ? red_cnt_q : blue_cnt_q;
			car_q   <= '0;
			moved_q <= '0;
		end
		unique case (state_q)
			ST_P1_RD: if (car_done) car_q <= '0;
			ST_P1_GR: pos_q <= pos_rdata[PW-1:0];
			ST_P1_DEC: car_q <= car_q + CW'(1);
			ST_P2_WT: begin
				pos_q  <= pos_rdata[PW-1:0];
				tgt_q  <= tgt;
				flag_q <= pos_rdata[PW];
				if (pos_rdata[PW]) moved_q <= moved_q + CW'(1);
			end
			ST_P2_WP: car_q <= car_q + CW'(1);
			default: ;
		endcase
		if (res.fin) begin
			read_value  <= res.rv;
			status      <= res.status;
			phase       <= res.phase;
			moved_count <= (state_q == ST_P2_RD) ? 11'(moved_q) : 11'd0;
		end
	end

	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_STEP |=> state_q == ST_P1_RD)
		else $error("step did not start decision pass");

	a_no_write_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P1_GR || state_q == ST_P1_DEC || state_q == ST_P1_RD) |-> !grid_we)
		else $error("grid written during decision pass");

	a_moved_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_P2_RD |-> moved_q <= car_q)
		else $error("moved count exceeds cars visited");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blue_cnt_q <= CW'(MAX_CARS) && red_cnt_q <= CW'(MAX_CARS))
		else $error("car list overfilled");

endmodule

/* tb/sv/testbench.sv */
module testbench import bml_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NROW = 64;
	localparam int NCOL = 64;
	localparam int NCELL = NROW * NCOL;
	localparam int NCAR = 1024;

	typedef struct {
		logic [2:0] act;
		logic [5:0] r;
		logic [5:0] c;
		logic [1:0] v;
	} beat_t;

	typedef struct {
		logic [1:0] rv;
		logic [10:0] moved;
		logic ph;
		logic st;
	} outcome_t;

	typedef struct {
		beat_t b;
		logic known;
		outcome_t o;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic [5:0] row = '0;
	logic [5:0] col = '0;
	logic [1:0] cell_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] read_value;
	logic [10:0] moved_count;
	logic phase;
	logic status;

	bml_traffic_step_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .row(row), .col(col), .cell_value(cell_value),
		.out_valid(out_valid), .out_ready(out_ready), .read_value(read_value),
		.moved_count(moved_count), .phase(phase), .status(status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [1:0] grid [2][NCELL];
	logic live;
	logic [11:0] blue_pos [NCAR];
	logic [11:0] red_pos [NCAR];
	int blue_n, red_n;
	logic step_ph;
	logic [6:0] rows_reg, cols_reg;

	outcome_t pending [$];
	int errors = 0;
	int beats_in = 0, beats_out = 0, steps_run = 0;
	bit calm = 1'b0;

	function automatic int clamp_dim(logic [6:0] v, int mx);
		if (v == 0) return 1;
		return (v > mx) ? mx : int'(v);
	endfunction

	function automatic void wipe_grid();
		for (int i = 0; i < NCELL; i++) begin
			grid[0][i] = CELL_EMPTY;
			grid[1][i] = CELL_EMPTY;
		end
		live = 1'b0;
		blue_n = 0;
		red_n = 0;
		step_ph = 1'b0;
	endfunction

	function automatic int run_step();
		int nr, nc, moved, p, r, c, t;
		logic nb;
		nr = clamp_dim(rows_reg, NROW);
		nc = clamp_dim(cols_reg, NCOL);
		nb = ~live;
		moved = 0;
		grid[nb] = grid[live];
		if (!step_ph) begin
			for (int a = 0; a < blue_n; a++) begin
				p = blue_pos[a];
				r = p / NCOL;
				c = p % NCOL;
				t = ((r == 0) ? nr - 1 : r - 1) * NCOL + c;
				if (grid[live][t] == CELL_EMPTY) begin
					grid[nb][t] = CELL_BLUE;
					grid[nb][p] = CELL_EMPTY;
					blue_pos[a] = t;
					moved++;
				end
			end
		end else begin
			for (int a = 0; a < red_n; a++) begin
				p = red_pos[a];
				r = p / NCOL;
				c = p % NCOL;
				t = r * NCOL + ((c + 1 >= nc) ? 0 : c + 1);
				if (grid[live][t] == CELL_EMPTY) begin
					grid[nb][t] = CELL_RED;
					grid[nb][p] = CELL_EMPTY;
					red_pos[a] = t;
					moved++;
				end
			end
		end
		live = nb;
		step_ph = ~step_ph;
		return moved;
	endfunction

	function automatic outcome_t traffic_predict(beat_t b);
		outcome_t o;
		logic ok;
		int idx;
		ok = (b.r < clamp_dim(rows_reg, NROW)) && (b.c < clamp_dim(cols_reg, NCOL));
		idx = int'(b.r) * NCOL + int'(b.c);
		o = '{rv: 2'd0, moved: 11'd0, ph: 1'b0, st: 1'b0};
		case (b.act)
			ACT_WRITE: begin
				if (!ok || b.v == CELL_BAD) o.st = 1'b1;
				else grid[live][idx] = b.v;
			end
			ACT_BLUE: begin
				if (!ok || blue_n >= NCAR) o.st = 1'b1;
				else begin
					blue_pos[blue_n] = idx[11:0];
					blue_n++;
					grid[live][idx] = CELL_BLUE;
				end
			end
			ACT_RED: begin
				if (!ok || red_n >= NCAR) o.st = 1'b1;
				else begin
					red_pos[red_n] = idx[11:0];
					red_n++;
					grid[live][idx] = CELL_RED;
				end
			end
			ACT_STEP: begin
				o.moved = 11'(run_step());
				steps_run++;
			end
			ACT_READ: begin
				if (!ok) o.st = 1'b1;
				else o.rv = grid[live][idx];
			end
			ACT_CLEAR: wipe_grid();
			default: o.st = 1'b1;
		endcase
		o.ph = step_ph;
		return o;
	endfunction

	task automatic idle_burst();
		repeat ($urandom_range(1, 7)) @(negedge clk);
	endtask

	task automatic send_beat(beat_t b, logic known, outcome_t o);
		outcome_t p;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			idle_burst();
		end
		in_valid <= 1'b1;
		action <= b.act;
		row <= b.r;
		col <= b.c;
		cell_value <= b.v;
		do @(posedge clk); while (!in_ready);
		p = traffic_predict(b);
		if (known) pending.push_back(o);
		else pending.push_back(p);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending.size() != 0);
	endtask

	task automatic drain();
		settle();
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ROWS) rows_reg = val;
		else cols_reg = val;
		@(negedge clk);
	endtask

	function automatic beat_t rand_beat(int nr, int nc);
		beat_t b;
		int k;
		k = $urandom_range(0, 99);
		b.act = (k < 30) ? ACT_BLUE : (k < 55) ? ACT_RED : (k < 75) ? ACT_STEP :
			(k < 88) ? ACT_READ : (k < 94) ? ACT_WRITE : (k < 96) ? ACT_CLEAR :
			3'($urandom_range(6, 7));
		if ($urandom_range(0, 9) == 0) begin
			b.r = 6'($urandom);
			b.c = 6'($urandom);
		end else begin
			b.r = 6'($urandom_range(0, nr - 1));
			b.c = 6'($urandom_range(0, nc - 1));
		end
		b.v = 2'($urandom);
		return b;
	endfunction

	always @(negedge clk) begin
		if (calm || $urandom_range(0, 4) != 0) out_ready <= 1'b1;
		else out_ready <= 1'b0;
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			beats_out++;
			if (pending.size() == 0) begin
				$display("%0t unexpected result rv=%0d moved=%0d phase=%0d status=%0d",
					$time, read_value, moved_count, phase, status);
				errors++;
			end else begin
				e = pending.pop_front();
				if (read_value !== e.rv || moved_count !== e.moved ||
					phase !== e.ph || status !== e.st) begin
					$display("%0t mismatch expected rv=%0d moved=%0d phase=%0d status=%0d",
						$time, e.rv, e.moved, e.ph, e.st);
					$display("%0t           actual rv=%0d moved=%0d phase=%0d status=%0d",
						$time, read_value, moved_count, phase, status);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		row_t tbl [$];
		int nr, nc;
		beat_t b;
		wipe_grid();
		rows_reg = 7'd64;
		cols_reg = 7'd64;
		tbl = '{
			'{'{ACT_READ, 6'd0, 6'd0, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_READ, 6'd63, 6'd63, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_WRITE, 6'd63, 6'd0, 2'd3}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b1}},
			'{'{ACT_WRITE, 6'd63, 6'd63, 2'd1}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_READ, 6'd63, 6'd63, 2'd0}, 1'b1, '{2'd1, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_WRITE, 6'd63, 6'd63, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_BLUE, 6'd0, 6'd0, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_BLUE, 6'd63, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_RED, 6'd5, 6'd63, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_RED, 6'd5, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_STEP, 6'd0, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_READ, 6'd63, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_STEP, 6'd0, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_READ, 6'd5, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_WRITE, 6'd1, 6'd1, 2'd2}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{3'd6, 6'd0, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b1}},
			'{'{3'd7, 6'd63, 6'd63, 2'd3}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b1}},
			'{'{ACT_CLEAR, 6'd0, 6'd0, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}},
			'{'{ACT_READ, 6'd0, 6'd0, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b0}}
		};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		foreach (tbl[i]) send_beat(tbl[i].b, tbl[i].known, tbl[i].o);
		drain();

		write_reg(CFG_ROWS, 7'd0);
		write_reg(CFG_COLS, 7'd127);
		send_beat('{ACT_READ, 6'd1, 6'd0, 2'd0}, 1'b1, '{2'd0, 11'd0, 1'b0, 1'b1});
		send_beat('{ACT_BLUE, 6'd0, 6'd63, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0});
		send_beat('{ACT_STEP, 6'd0, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0});
		send_beat('{ACT_STEP, 6'd0, 6'd0, 2'd0}, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0});
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(CFG_ROWS, 7'd4); write_reg(CFG_COLS, 7'd5); end
				1: begin write_reg(CFG_ROWS, 7'd64); write_reg(CFG_COLS, 7'd64); end
				2: begin write_reg(CFG_ROWS, 7'd2); write_reg(CFG_COLS, 7'd3); end
				3: begin write_reg(CFG_ROWS, 7'd8); write_reg(CFG_COLS, 7'd1); end
				default: begin write_reg(CFG_ROWS, 7'd6); write_reg(CFG_COLS, 7'd7); end
			endcase
			nr = clamp_dim(rows_reg, NROW);
			nc = clamp_dim(cols_reg, NCOL);
			calm = (ph == 4);
			for (int k = 0; k < 54; k++) begin
				b = rand_beat(nr, nc);
				send_beat(b, 1'b0, '{2'd0, 11'd0, 1'b0, 1'b0});
				if (ph == 2 && k == 20) settle();
			end
			drain();
		end

		$display("Sent %0d beats, checked %0d results, %0d advance steps, 6 grid sizes.",
			beats_in, beats_out, steps_run);
		if (errors == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule
